/* design/assert_macros.svh */
// Assertion helpers included by the window_sum_closest_match design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/wscm_pkg.sv */
package wscm_pkg;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_COLS    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_ROWS    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_VALUE = 2'd2;

  localparam int GRID_COLS_BITS = 11;
  localparam int GRID_ROWS_BITS = 16;
  localparam int TARGET_BITS    = 32;

  localparam int ROW_BITS      = 16;
  localparam int COL_OUT_BITS  = 10;
  localparam int DIFF_OUT_BITS = 32;

  localparam logic [GRID_COLS_BITS-1:0] GRID_COLS_RESET = 11'd3;
  localparam logic [GRID_ROWS_BITS-1:0] GRID_ROWS_RESET = 16'd3;

  typedef struct packed {
    logic [ROW_BITS-1:0]      row;
    logic [COL_OUT_BITS-1:0]  col;
    logic [DIFF_OUT_BITS-1:0] diff;
    logic                     found;
  } result_t;

endpackage

/* design/window_sum_closest_match.sv */
// Streams a grid of signed samples in row-major order, one sample per beat, and
// finds the 3x3 window whose sum lies closest to target_value (earliest window in
// row-major order wins a tie). One result beat leaves after the last sample of each
// grid: the center row and column of the best window, |target - sum|, and found=1;
// a grid with fewer than three rows or columns gives found=0 and zeros. A sample is
// taken every clock: the two previous rows sit in two line memories of MAX_COLS
// entries whose read port is aimed at the column of the next beat, and the
// nine-way add, subtract and compare finish in the cycle the sample is taken. The
// result stays in an output register; the input stalls only while that register
// is full and the output is stalled. Program grid_cols, grid_rows and target_value
// between grids; no clearing pass is needed after reset.
`include "assert_macros.svh"

module window_sum_closest_match #(
  parameter int MAX_COLS    = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [SAMPLE_BITS-1:0]           sample,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [wscm_pkg::ROW_BITS-1:0]           best_row,
  output logic [wscm_pkg::COL_OUT_BITS-1:0]       best_col,
  output logic [wscm_pkg::DIFF_OUT_BITS-1:0]      best_diff,
  output logic                                    found,
  input  logic                                    cfg_write,
  input  logic [wscm_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [wscm_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  localparam int CW  = $clog2(MAX_COLS);
  localparam int CSW = SAMPLE_BITS + 2;
  localparam int SW  = SAMPLE_BITS + 4;
  localparam int DW  = ((SW > wscm_pkg::TARGET_BITS) ? SW : wscm_pkg::TARGET_BITS) + 1;
  localparam int RB  = wscm_pkg::ROW_BITS;

  // configuration
  logic [wscm_pkg::GRID_COLS_BITS-1:0] grid_cols;
  logic [wscm_pkg::GRID_ROWS_BITS-1:0] grid_rows;
  logic signed [wscm_pkg::TARGET_BITS-1:0] target_value;

  // line memories
  logic [SAMPLE_BITS-1:0] mem_upper  [MAX_COLS];
  logic [SAMPLE_BITS-1:0] mem_middle [MAX_COLS];
  logic [SAMPLE_BITS-1:0] rd_upper;
  logic [SAMPLE_BITS-1:0] rd_middle;
  logic                   byp_valid;
  logic [SAMPLE_BITS-1:0] byp_upper;
  logic [SAMPLE_BITS-1:0] byp_middle;

  // window as two column sums, older first
  logic signed [CSW-1:0] col_sum_a;
  logic signed [CSW-1:0] col_sum_b;

  logic [RB-1:0] row_count;
  logic [CW-1:0] col_count;
  logic [DW-1:0] best_diff_reg;
  logic [RB-1:0] best_row_reg;
  logic [CW-1:0] best_col_reg;
  logic          have_best;

  wscm_pkg::result_t res;

  // datapath
  logic                   in_acc;
  logic signed [SAMPLE_BITS-1:0] up;
  logic signed [SAMPLE_BITS-1:0] mid;
  logic signed [CSW-1:0]  col_sum_new;
  logic signed [SW-1:0]   win_sum;
  logic signed [DW-1:0]   delta;
  logic [DW-1:0]          diff_abs;
  logic [31:0]            cols_lim;
  logic [31:0]            rows_lim;
  logic                   last_col;
  logic                   last_row;
  logic                   grid_end;
  logic                   interior;
  logic                   better;
  logic                   have_best_next;
  logic [DW-1:0]          best_diff_next;
  logic [RB-1:0]          best_row_next;
  logic [CW-1:0]          best_col_next;
  logic [CW-1:0]          col_count_next;
  logic [RB-1:0]          row_count_next;

  assign in_stall = out_valid & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  // forward the column written last cycle when it is read again at once
  assign up  = byp_valid ? byp_upper  : rd_upper;
  assign mid = byp_valid ? byp_middle : rd_middle;

  assign col_sum_new = CSW'(up) + CSW'(mid) + CSW'(sample);
  assign win_sum     = SW'(col_sum_a) + SW'(col_sum_b) + SW'(col_sum_new);
  assign delta       = DW'(target_value) - DW'(win_sum);
  assign diff_abs    = delta[DW-1] ? DW'(-delta) : DW'(delta);

  always_comb begin
    if (grid_cols == '0) begin
      cols_lim = 32'd1;
    end else if (32'(grid_cols) > 32'(MAX_COLS)) begin
      cols_lim = 32'(MAX_COLS);
    end else begin
      cols_lim = 32'(grid_cols);
    end
    rows_lim = (grid_rows == '0) ? 32'd1 : 32'(grid_rows);
  end

  assign last_col = 32'(col_count) >= (cols_lim - 32'd1);
  assign last_row = 32'(row_count) >= (rows_lim - 32'd1);
  assign grid_end = last_col & last_row;

  assign interior = (row_count >= RB'(2)) && (col_count >= CW'(2));
  assign better   = interior && (!have_best || (diff_abs < best_diff_reg));

  assign have_best_next = have_best | interior;
  assign best_diff_next = better ? diff_abs : best_diff_reg;
  assign best_row_next  = better ? (row_count - RB'(1)) : best_row_reg;
  assign best_col_next  = better ? (col_count - CW'(1)) : best_col_reg;

  always_comb begin
    col_count_next = col_count;
    row_count_next = row_count;
    if (in_acc) begin
      if (grid_end) begin
        col_count_next = '0;
        row_count_next = '0;
      end else if (last_col) begin
        col_count_next = '0;
        row_count_next = row_count + RB'(1);
      end else begin
        col_count_next = col_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols    <= wscm_pkg::GRID_COLS_RESET;
      grid_rows    <= wscm_pkg::GRID_ROWS_RESET;
      target_value <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        wscm_pkg::REG_GRID_COLS:    grid_cols    <= cfg_data[wscm_pkg::GRID_COLS_BITS-1:0];
        wscm_pkg::REG_GRID_ROWS:    grid_rows    <= cfg_data[wscm_pkg::GRID_ROWS_BITS-1:0];
        wscm_pkg::REG_TARGET_VALUE: target_value <= cfg_data[wscm_pkg::TARGET_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read port always points at the column of the next beat
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem_upper[col_count]  <= mid;
      mem_middle[col_count] <= sample;
    end
    rd_upper  <= mem_upper[col_count_next];
    rd_middle <= mem_middle[col_count_next];
  end

  always_ff @(posedge clk) begin
    byp_upper  <= mid;
    byp_middle <= sample;
    if (rst) begin
      byp_valid <= 1'b0;
    end else begin
      byp_valid <= in_acc && (col_count_next == col_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_sum_a     <= '0;
      col_sum_b     <= '0;
      row_count     <= '0;
      col_count     <= '0;
      best_diff_reg <= '0;
      best_row_reg  <= '0;
      best_col_reg  <= '0;
      have_best     <= 1'b0;
    end else begin
      row_count <= row_count_next;
      col_count <= col_count_next;
      if (in_acc) begin
        if (grid_end) begin
          col_sum_a     <= '0;
          col_sum_b     <= '0;
          best_diff_reg <= '0;
          best_row_reg  <= '0;
          best_col_reg  <= '0;
          have_best     <= 1'b0;
        end else begin
          col_sum_a     <= col_sum_b;
          col_sum_b     <= col_sum_new;
          best_diff_reg <= best_diff_next;
          best_row_reg  <= best_row_next;
          best_col_reg  <= best_col_next;
          have_best     <= have_best_next;
        end
      end
    end
  end

  // result register: load at grid end, drop once taken
  always_ff @(posedge clk) begin
    if (in_acc && grid_end) begin
      res.found <= have_best_next;
      if (have_best_next) begin
        res.row  <= best_row_next;
        res.col  <= wscm_pkg::COL_OUT_BITS'(32'(best_col_next));
        res.diff <= wscm_pkg::DIFF_OUT_BITS'(best_diff_next);
      end else begin
        res.row  <= '0;
        res.col  <= '0;
        res.diff <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && grid_end) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign best_row  = res.row;
  assign best_col  = res.col;
  assign best_diff = res.diff;
  assign found     = res.found;

  `ASSERT_CLK(a_grid_end_emits, (in_acc && grid_end) |=> out_valid, "grid end gave no result")
  `ASSERT_CLK(a_best_interior, have_best |-> (row_count >= RB'(2)), "best set outside interior")
  `ASSERT_CLK(a_empty_zero, (out_valid && !found) |-> (best_row == '0 && best_col == '0 && best_diff == '0), "empty grid result not zero")

endmodule
